FILE: sv/inter_spike_interval_histogram_defines.svh
// Assertion macros for the inter-spike interval histogram.
// Bodies refer to clk and rst_n of the including module.
`ifndef INTER_SPIKE_INTERVAL_HISTOGRAM_DEFINES_SVH
`define INTER_SPIKE_INTERVAL_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ISIH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISIH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/isih_pkg.sv
// Package for the inter-spike interval histogram: sizes, codes and payload types.
// No dependencies.
`default_nettype none

package isih_pkg;

  localparam int HISTORY = 64;
  localparam int BINS    = 1024;

  localparam int RING_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int CNT_W  = $clog2(HISTORY + 1);
  localparam int BIN_W  = $clog2(BINS);

  localparam int OP_W       = 2;
  localparam int TIME_W     = 32;
  localparam int IDX_W      = 10;
  localparam int COUNT_W    = 32;
  localparam int PAIRS_W    = 7;
  localparam int ORDER_W    = 7;
  localparam int MAXB_W     = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_ADDR_W-1:0] REG_SPIKE_ORDER = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_BINS    = 1'b1;

  localparam logic [OP_W-1:0] OP_SPIKE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [ORDER_W-1:0] SPIKE_ORDER_RST = 7'd0;
  localparam logic [MAXB_W-1:0]  MAX_BINS_RST    = 11'd1024;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] spike_time;
    logic [IDX_W-1:0]  bin_index;
  } isih_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [PAIRS_W-1:0] pairs_added;
    logic               saturated;
  } isih_out_t;

endpackage

`default_nettype wire

FILE: sv/inter_spike_interval_histogram.sv
// Spike-interval histogram with a spike time ring and a single-port bin memory.
// Depends on isih_pkg and inter_spike_interval_histogram_defines.svh.
// Spike: the new time is paired with the L newest stored spikes (H of them hit a bin),
//   and each hit is counted by a read-modify-write of the bin memory.
// One transaction at a time.
// Reset: synchronous; a clearing pass zeroes the bins, not ready meanwhile.
`default_nettype none
`include "inter_spike_interval_histogram_defines.svh"

module inter_spike_interval_histogram
  import isih_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire isih_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output isih_out_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAIR_RD,
    ST_PAIR_WR,
    ST_SPIKE_END,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

  state_t               state_r;
  logic [ORDER_W-1:0]   spike_order_r;
  logic [MAXB_W-1:0]    max_bins_r;
  logic [RING_W-1:0]    head_r;
  logic [CNT_W-1:0]     stored_r;
  logic [RING_W-1:0]    ptr_r;
  logic [CNT_W-1:0]     k_r;
  logic [CNT_W-1:0]     limit_r;
  logic [TIME_W-1:0]    time_r;
  logic [BIN_W-1:0]     bin_r;
  logic                 last_r;
  logic                 rd_ok_r;
  logic [COUNT_W-1:0]   res_count_r;
  logic [PAIRS_W-1:0]   res_pairs_r;
  logic                 res_sat_r;
  logic [BIN_W-1:0]     clr_addr_r;
  logic                 clr_reply_r;
  logic                 out_valid_r;
  isih_out_t            out_data_r;

  logic [TIME_W-1:0]    ring_mem [HISTORY];
  logic [TIME_W-1:0]    ring_rd_r;
  logic [COUNT_W-1:0]   hist_mem [BINS];
  logic [COUNT_W-1:0]   hist_rd_r;

  logic                 accept;
  logic                 out_free;
  logic [CNT_W-1:0]     acc_limit;
  logic [RING_W-1:0]    newest_ptr;
  logic [RING_W-1:0]    prev_ptr;
  logic [RING_W-1:0]    head_nxt;
  logic [TIME_W-1:0]    diff;
  logic                 hit;
  logic [CNT_W-1:0]     k_inc;
  logic                 last_pair;
  logic                 bin_full;
  logic [PAIRS_W-1:0]   pairs_inc;
  logic                 rd_in_range;

  logic                 ring_re;
  logic                 ring_we;
  logic [RING_W-1:0]    ring_raddr;
  logic                 hist_re;
  logic [BIN_W-1:0]     hist_raddr;
  logic                 hist_we;
  logic [BIN_W-1:0]     hist_waddr;
  logic [COUNT_W-1:0]   hist_wdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  assign acc_limit = ((spike_order_r != '0) && (32'(spike_order_r) < 32'(stored_r)))
                   ? CNT_W'(spike_order_r) : stored_r;
  assign newest_ptr = (head_r == '0) ? RING_W'(HISTORY - 1) : head_r - RING_W'(1);
  assign prev_ptr   = (ptr_r == '0) ? RING_W'(HISTORY - 1) : ptr_r - RING_W'(1);
  assign head_nxt   = (head_r == RING_W'(HISTORY - 1)) ? '0 : head_r + RING_W'(1);

  assign diff      = time_r - ring_rd_r;
  assign hit       = (diff < 32'(max_bins_r)) && (diff < 32'(BINS));
  assign k_inc     = k_r + CNT_W'(1);
  assign last_pair = (k_inc == limit_r);
  assign bin_full  = (hist_rd_r == '1);
  assign pairs_inc = (res_pairs_r == '1) ? res_pairs_r : res_pairs_r + PAIRS_W'(1);
  assign rd_in_range = 32'(in_data.bin_index) < 32'(BINS);

  always_comb begin
    ring_re    = 1'b0;
    ring_we    = 1'b0;
    ring_raddr = newest_ptr;
    hist_re    = 1'b0;
    hist_raddr = BIN_W'(in_data.bin_index);
    hist_we    = 1'b0;
    hist_waddr = clr_addr_r;
    hist_wdata = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.op == OP_SPIKE)) begin
          ring_re = (acc_limit != '0);
        end
        if (accept && (in_data.op == OP_READ)) begin
          hist_re = 1'b1;
        end
      end
      ST_PAIR_RD: begin
        ring_re    = !last_pair;
        ring_raddr = prev_ptr;
        hist_re    = 1'b1;
        hist_raddr = diff[BIN_W-1:0];
      end
      ST_PAIR_WR: begin
        hist_we    = !bin_full;
        hist_waddr = bin_r;
        hist_wdata = hist_rd_r + COUNT_W'(1);
      end
      ST_CLEAR: begin
        hist_we = 1'b1;
      end
      ST_SPIKE_END: begin
        ring_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[head_r] <= time_r;
    end
    if (ring_re) begin
      ring_rd_r <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      spike_order_r <= SPIKE_ORDER_RST;
      max_bins_r    <= MAX_BINS_RST;
      head_r        <= '0;
      stored_r      <= '0;
      clr_addr_r    <= '0;
      clr_reply_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SPIKE_ORDER: spike_order_r <= cfg_wdata[ORDER_W-1:0];
          REG_MAX_BINS:    max_bins_r    <= cfg_wdata[MAXB_W-1:0];
        endcase
      end
      if (out_valid_r && out_ready && (state_r != ST_RESULT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (clr_addr_r == BIN_W'(BINS - 1)) begin
            clr_addr_r <= '0;
            state_r    <= clr_reply_r ? ST_RESULT : ST_IDLE;
          end else begin
            clr_addr_r <= clr_addr_r + BIN_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            time_r      <= in_data.spike_time;
            res_count_r <= '0;
            res_pairs_r <= '0;
            res_sat_r   <= 1'b0;
            k_r         <= '0;
            limit_r     <= acc_limit;
            ptr_r       <= newest_ptr;
            rd_ok_r     <= rd_in_range;
            unique case (in_data.op)
              OP_SPIKE: state_r <= (acc_limit == '0) ? ST_SPIKE_END : ST_PAIR_RD;
              OP_READ:  state_r <= ST_READ_WAIT;
              OP_CLEAR: begin
                head_r      <= '0;
                stored_r    <= '0;
                clr_addr_r  <= '0;
                clr_reply_r <= 1'b1;
                state_r     <= ST_CLEAR;
              end
              default:  state_r <= ST_RESULT;
            endcase
          end
        end
        ST_PAIR_RD: begin
          k_r    <= k_inc;
          ptr_r  <= prev_ptr;
          bin_r  <= diff[BIN_W-1:0];
          last_r <= last_pair;
          if (hit) begin
            state_r <= ST_PAIR_WR;
          end else if (last_pair) begin
            state_r <= ST_SPIKE_END;
          end
        end
        ST_PAIR_WR: begin
          if (bin_full) begin
            res_sat_r <= 1'b1;
          end
          res_pairs_r <= pairs_inc;
          state_r     <= last_r ? ST_SPIKE_END : ST_PAIR_RD;
        end
        ST_SPIKE_END: begin
          head_r <= head_nxt;
          if (stored_r != CNT_W'(HISTORY)) begin
            stored_r <= stored_r + CNT_W'(1);
          end
          state_r <= ST_RESULT;
        end
        ST_READ_WAIT: begin
          res_count_r <= rd_ok_r ? hist_rd_r : '0;
          state_r     <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.bin_count   <= res_count_r;
            out_data_r.pairs_added <= res_pairs_r;
            out_data_r.saturated   <= res_sat_r;
            state_r                <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `ISIH_ASSERT_IMPL(a_pair_in_range, state_r == ST_PAIR_RD, k_r < limit_r, "pair index past limit")
  `ISIH_ASSERT_IMPL(a_wr_after_rd, state_r == ST_PAIR_WR, $past(state_r) == ST_PAIR_RD, "bin write without read")
  `ISIH_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after transaction accept")

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for inter_spike_interval_histogram: directed table, then random phases.
// Uses the isih_pkg types; expected results come from the table for typed rows, else from an in-bench predictor.
`default_nettype none

module tb;
  import isih_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 8 * (BINS + 2 * HISTORY + 3);
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;

  typedef struct {
    isih_in_t  item;
    bit        typed;
    isih_out_t result;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  isih_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  isih_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic [TIME_W-1:0]  spike_times [HISTORY];
  logic [COUNT_W-1:0] bin_counts [BINS];
  int                 ring_slot;
  int                 ring_fill;
  logic [ORDER_W-1:0] cur_order;
  logic [MAXB_W-1:0]  cur_max_bins;

  isih_out_t due_results [$];
  stim_row_t sent_rows [$];
  stim_row_t dir_tab [$];

  int idle_pct;
  int stall_pct;
  int mismatch_count;
  int quiet_cycles;

  inter_spike_interval_histogram i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_histogram();
    ring_slot = 0;
    ring_fill = 0;
    for (int b = 0; b < BINS; b++) bin_counts[b] = '0;
  endfunction

  function automatic isih_out_t histogram_step(isih_in_t it);
    isih_out_t r;
    int unsigned lim;
    int unsigned lim_bins;
    int slot;
    logic [TIME_W-1:0] d;
    r = '0;
    case (it.op)
      OP_SPIKE: begin
        lim = ring_fill;
        lim_bins = (cur_max_bins > BINS) ? BINS : cur_max_bins;
        if (cur_order != 0 && cur_order < lim) lim = cur_order;
        for (int k = 0; k < lim; k++) begin
          slot = (ring_slot + HISTORY - 1 - k) % HISTORY;
          d = it.spike_time - spike_times[slot];
          if (d < lim_bins) begin
            if (bin_counts[d] == '1) r.saturated = 1'b1;
            else bin_counts[d] = bin_counts[d] + 1;
            if (r.pairs_added < 7'd127) r.pairs_added = PAIRS_W'(r.pairs_added + 1);
          end
        end
        spike_times[ring_slot] = it.spike_time;
        ring_slot = (ring_slot + 1) % HISTORY;
        if (ring_fill < HISTORY) ring_fill++;
      end
      OP_READ: begin
        if (it.bin_index < BINS) r.bin_count = bin_counts[it.bin_index];
      end
      OP_CLEAR: begin
        clear_histogram();
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t row(logic [OP_W-1:0] op, logic [TIME_W-1:0] t,
                                    logic [IDX_W-1:0] idx, bit typed,
                                    logic [COUNT_W-1:0] cnt, logic [PAIRS_W-1:0] pairs);
    stim_row_t r;
    r.item.op = op;
    r.item.spike_time = t;
    r.item.bin_index = idx;
    r.typed = typed;
    r.result.bin_count = cnt;
    r.result.pairs_added = pairs;
    r.result.saturated = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : monitor
    isih_out_t want;
    isih_out_t pred;
    stim_row_t sent;
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (due_results.size() == 0) begin
          $error("result with no pending transaction: %h", out_data);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (out_data.bin_count !== want.bin_count) begin
            $error("bin_count: expected %0d, got %0d", want.bin_count, out_data.bin_count);
            mismatch_count++;
          end
          if (out_data.pairs_added !== want.pairs_added) begin
            $error("pairs_added: expected %0d, got %0d", want.pairs_added,
                   out_data.pairs_added);
            mismatch_count++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, out_data.saturated);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        pred = histogram_step(in_data);
        sent = sent_rows.pop_front();
        due_results.push_back(sent.typed ? sent.result : pred);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input stim_row_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    sent_rows.push_back(r);
    in_valid <= 1'b1;
    in_data <= r.item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_setting(input int order_val, input int maxb_val);
    logic [CFG_DATA_W-1:0] w;
    drain();
    repeat (4) @(posedge clk);
    w = CFG_DATA_W'(order_val);
    w[CFG_DATA_W-1:ORDER_W] = 4'($urandom_range(0, 15));
    cfg_we <= 1'b1;
    cfg_addr <= REG_SPIKE_ORDER;
    cfg_wdata <= w;
    cur_order = w[ORDER_W-1:0];
    @(posedge clk);
    cfg_addr <= REG_MAX_BINS;
    cfg_wdata <= CFG_DATA_W'(maxb_val);
    cur_max_bins = MAXB_W'(maxb_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : main
    stim_row_t r;
    logic [TIME_W-1:0] seq_time;
    int sel;
    int n;
    int o;
    int m;

    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    quiet_cycles = 0;
    for (int s = 0; s < HISTORY; s++) spike_times[s] = '0;
    clear_histogram();
    cur_order = SPIKE_ORDER_RST;
    cur_max_bins = MAX_BINS_RST;

    dir_tab.push_back(row(OP_READ,   32'd0,          10'd0,     1, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_READ,   32'hFFFF_FFFF,  10'h3FF,   1, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'd0,          10'h3FF,   1, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'd5,          10'd0,     1, 32'd0, 7'd1));
    dir_tab.push_back(row(OP_READ,   32'd0,          10'd5,     1, 32'd1, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'd5,          10'd0,     0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'd1028,       10'd0,     0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_READ,   32'd0,          10'd1023,  0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_READ,   32'd0,          10'd0,     0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'd3,          10'd0,     0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_UNUSED, 32'hFFFF_FFFF,  10'h3FF,   1, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_CLEAR,  32'hFFFF_FFFF,  10'h3FF,   1, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_READ,   32'd0,          10'd5,     1, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'hFFFF_FFFE,  10'd0,     1, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'hFFFF_FFFF,  10'd0,     1, 32'd0, 7'd1));
    dir_tab.push_back(row(OP_SPIKE,  32'h0000_0002,  10'd0,     0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_READ,   32'd0,          10'd3,     0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_READ,   32'h5555_5555,  10'h2AA,   0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_READ,   32'hAAAA_AAAA,  10'h155,   0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'h5555_5555,  10'h2AA,   0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_SPIKE,  32'hAAAA_AAAA,  10'h155,   0, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_CLEAR,  32'd0,          10'd0,     1, 32'd0, 7'd0));
    dir_tab.push_back(row(OP_READ,   32'd0,          10'd1,     1, 32'd0, 7'd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    seq_time = $urandom();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin o = 0; m = 1024; idle_pct = 0; stall_pct = 0; end
        1: begin o = 1; m = 1; idle_pct = 56; stall_pct = 0; end
        2: begin o = 64; m = 2047; idle_pct = 0; stall_pct = 56; end
        3: begin o = 127; m = 0; idle_pct = 28; stall_pct = 28; end
        4: begin o = 3; m = 37; idle_pct = 0; stall_pct = 0; end
        5: begin o = $urandom_range(0, 127); m = $urandom_range(0, 2047);
                 idle_pct = 56; stall_pct = 0; end
        6: begin o = 0; m = 1024; idle_pct = 0; stall_pct = 56; end
        default: begin o = $urandom_range(0, 127); m = $urandom_range(0, 2047);
                       idle_pct = 28; stall_pct = 28; end
      endcase
      write_setting(o, m);
      n = 0;
      while (n < PHASE_ITEMS) begin
        r.typed = 1'b0;
        r.result = '0;
        r.item.spike_time = $urandom();
        r.item.bin_index = IDX_W'($urandom_range(0, 1023));
        sel = $urandom_range(0, 99);
        if (sel < 2) begin
          r.item.op = OP_CLEAR;
          seq_time = $urandom();
        end else if (sel < 55) begin
          r.item.op = OP_SPIKE;
          case ($urandom_range(0, 3))
            0: seq_time = seq_time + $urandom_range(0, 2);
            3: seq_time = seq_time + $urandom_range(0, 1200);
            default: seq_time = seq_time + $urandom_range(0, 24);
          endcase
          r.item.spike_time = seq_time;
        end else if (sel < 90) begin
          r.item.op = OP_READ;
          if ($urandom_range(0, 1) == 0) r.item.bin_index = IDX_W'($urandom_range(0, 63));
        end else if (sel < 94) begin
          r.item.op = OP_UNUSED;
        end else if (sel < 97) begin
          r.item.op = OP_SPIKE;
        end else begin
          r.item.op = OP_SPIKE;
          r.item.spike_time = seq_time - $urandom_range(1, 100);
        end
        send_item(r);
        if (r.item.op != OP_UNUSED) n++;
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (2 * HISTORY + 8) @(posedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
